@@ rtl/audio_dc_remove_decimate_capture_unit_assert.svh @@
`ifndef AUDIO_DC_REMOVE_DECIMATE_CAPTURE_UNIT_ASSERT_SVH
`define AUDIO_DC_REMOVE_DECIMATE_CAPTURE_UNIT_ASSERT_SVH

// property that must hold at every edge out of reset
`define DCRD_ASSERT_HOLDS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("port check failed");

// property of the form antecedent |=> consequent
`define DCRD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("port check failed");

// property of the form antecedent |-> consequent
`define DCRD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("port check failed");

`endif

@@ rtl/dcrd_pkg.sv @@
package dcrd_pkg;

    localparam int ADC_BITS    = 12;
    localparam int FRAC_BITS   = 16;
    localparam int OFF_W       = ADC_BITS + FRAC_BITS;
    localparam int DECIM_RATIO = 5;
    localparam int PHASE_W     = $clog2(DECIM_RATIO);
    localparam int CLIP_W      = 15;
    localparam int WARM_W      = 14;
    localparam int SHIFT_W     = 4;
    localparam int COEFF_W     = 16;
    localparam int PCM_W       = 16;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LENGTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_SAMPLES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PCM_SHIFT      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EMA_COEFF      = 2'd3;

    localparam logic [CLIP_W-1:0]  CLIP_LENGTH_RESET = 15'd24000;
    localparam logic [WARM_W-1:0]  WARMUP_RESET      = 14'd10000;
    localparam logic [SHIFT_W-1:0] PCM_SHIFT_RESET   = 4'd4;
    localparam logic [COEFF_W-1:0] EMA_COEFF_RESET   = 16'd328;
    // mid scale of the converter in integer.fraction form
    localparam logic [OFF_W-1:0]   OFFSET_RESET      = OFF_W'(1) << (OFF_W - 1);

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_START  = 1'b1;

    typedef struct packed {
        logic                op;
        logic [ADC_BITS-1:0] adc_sample;
    } in_item_t;

    typedef struct packed {
        logic signed [PCM_W-1:0] pcm_sample;
        logic                    last_of_clip;
    } out_item_t;

    // work handed from front to back: every entry updates the filter
    typedef struct packed {
        logic [ADC_BITS-1:0] x;
        logic                emit;
        logic                last;
    } cmd_t;

    typedef struct packed {
        logic [COEFF_W-1:0] coeff;
        logic [SHIFT_W-1:0] shift;
    } filt_cfg_t;

endpackage

@@ rtl/dcrd_queue.sv @@
module dcrd_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dcrd_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output dcrd_pkg::cmd_t pop_cmd
);

    dcrd_pkg::cmd_t mem [dcrd_pkg::QDEPTH];

    logic [dcrd_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [dcrd_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [dcrd_pkg::QPTR_W:0]   count_reg;
    logic [dcrd_pkg::QPTR_W:0]   count_next;

    assign full    = (count_reg == (dcrd_pkg::QPTR_W+1)'(dcrd_pkg::QDEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ rtl/dcrd_front.sv @@
module dcrd_front
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  dcrd_pkg::in_item_t                 in_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dcrd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dcrd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               q_full,
    output logic                               push,
    output dcrd_pkg::cmd_t                     push_cmd,
    output dcrd_pkg::filt_cfg_t                filt_cfg
);

    logic [dcrd_pkg::CLIP_W-1:0]  clip_length_reg;
    logic [dcrd_pkg::SHIFT_W-1:0] pcm_shift_reg;
    logic [dcrd_pkg::COEFF_W-1:0] ema_coeff_reg;

    logic [dcrd_pkg::WARM_W-1:0]  warmup_left_reg, warmup_left_next;
    logic                         start_pending_reg, start_pending_next;
    logic                         capturing_reg, capturing_next;
    logic [dcrd_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [dcrd_pkg::CLIP_W-1:0]  emitted_reg, emitted_next;

    logic                         accept;
    logic                         cfg_write;
    logic                         cap;
    logic                         keep;
    logic [dcrd_pkg::CLIP_W-1:0]  emitted_inc;
    logic                         is_last;

    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    assign filt_cfg.coeff = ema_coeff_reg;
    assign filt_cfg.shift = pcm_shift_reg;

    always_comb
    begin
        warmup_left_next   = warmup_left_reg;
        start_pending_next = start_pending_reg;
        capturing_next     = capturing_reg;
        phase_next         = phase_reg;
        emitted_next       = emitted_reg;
        push               = 1'b0;
        push_cmd.x         = in_data.adc_sample;
        push_cmd.emit      = 1'b0;
        push_cmd.last      = 1'b0;
        cap                = capturing_reg;
        keep               = (phase_reg != dcrd_pkg::PHASE_W'(dcrd_pkg::DECIM_RATIO - 1));
        emitted_inc        = emitted_reg + 1'b1;
        is_last            = (emitted_inc >= clip_length_reg) || (emitted_inc == '0);

        if (cfg_write && cfg_index == dcrd_pkg::CFG_WARMUP_SAMPLES && warmup_left_reg != '0)
        begin
            warmup_left_next = cfg_data[dcrd_pkg::WARM_W-1:0];
        end

        if (accept)
        begin
            if (in_data.op == dcrd_pkg::OP_START)
            begin
                if (!capturing_reg && clip_length_reg != '0)
                begin
                    if (warmup_left_reg != '0)
                    begin
                        start_pending_next = 1'b1;
                    end
                    else
                    begin
                        capturing_next = 1'b1;
                        phase_next     = '0;
                        emitted_next   = '0;
                    end
                end
            end
            else if (warmup_left_reg != '0)
            begin
                // settling beat: filter only
                push             = 1'b1;
                warmup_left_next = warmup_left_reg - 1'b1;
            end
            else
            begin
                // phase and count already sit at zero whenever not capturing
                if (!capturing_reg && start_pending_reg)
                begin
                    start_pending_next = 1'b0;
                    cap                = (clip_length_reg != '0);
                end
                capturing_next = cap;
                if (cap)
                begin
                    push          = 1'b1;
                    push_cmd.emit = keep;
                    if (!keep)
                    begin
                        phase_next = '0;
                    end
                    else
                    begin
                        phase_next = phase_reg + 1'b1;
                        if (is_last)
                        begin
                            push_cmd.last  = 1'b1;
                            capturing_next = 1'b0;
                            emitted_next   = '0;
                            phase_next     = '0;
                        end
                        else
                        begin
                            emitted_next = emitted_inc;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_length_reg   <= dcrd_pkg::CLIP_LENGTH_RESET;
            pcm_shift_reg     <= dcrd_pkg::PCM_SHIFT_RESET;
            ema_coeff_reg     <= dcrd_pkg::EMA_COEFF_RESET;
            warmup_left_reg   <= dcrd_pkg::WARMUP_RESET;
            start_pending_reg <= 1'b0;
            capturing_reg     <= 1'b0;
            phase_reg         <= '0;
            emitted_reg       <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    dcrd_pkg::CFG_CLIP_LENGTH:
                    begin
                        clip_length_reg <= cfg_data[dcrd_pkg::CLIP_W-1:0];
                    end
                    dcrd_pkg::CFG_PCM_SHIFT:
                    begin
                        pcm_shift_reg <= cfg_data[dcrd_pkg::SHIFT_W-1:0];
                    end
                    dcrd_pkg::CFG_EMA_COEFF:
                    begin
                        ema_coeff_reg <= cfg_data[dcrd_pkg::COEFF_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            warmup_left_reg   <= warmup_left_next;
            start_pending_reg <= start_pending_next;
            capturing_reg     <= capturing_next;
            phase_reg         <= phase_next;
            emitted_reg       <= emitted_next;
        end
    end

endmodule

@@ rtl/dcrd_back.sv @@
module dcrd_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  dcrd_pkg::cmd_t      q_cmd,
    output logic                pop,
    input  dcrd_pkg::filt_cfg_t filt_cfg,
    output logic                out_valid,
    input  logic                out_ready,
    output dcrd_pkg::out_item_t out_data
);

    localparam int PROD_W = dcrd_pkg::OFF_W + dcrd_pkg::COEFF_W + 2;

    logic [dcrd_pkg::OFF_W-1:0]        dc_reg, dc_next;
    logic                              s1_valid_reg, s1_valid_next;
    dcrd_pkg::cmd_t                    s1_cmd_reg;
    logic                              out_valid_reg, out_valid_next;
    dcrd_pkg::out_item_t               out_data_reg;

    logic                              out_free;
    logic                              s1_free;
    logic                              out_load;

    logic signed [dcrd_pkg::OFF_W:0]   diff_f;
    logic signed [dcrd_pkg::COEFF_W:0] coef_s;
    logic signed [PROD_W-1:0]          prod;
    logic signed [PROD_W-1:0]          rnd;
    logic signed [PROD_W-1:0]          step;

    logic signed [dcrd_pkg::OFF_W:0]    diff_o;
    logic signed [dcrd_pkg::ADC_BITS:0] ipart;
    logic signed [dcrd_pkg::ADC_BITS:0] ipart_t;
    logic        [dcrd_pkg::PCM_W-1:0]  ext;
    logic        [dcrd_pkg::PCM_W-1:0]  pcm;

    assign out_free = !out_valid_reg || out_ready;
    assign s1_free  = !s1_valid_reg || !s1_cmd_reg.emit || out_free;
    assign out_load = s1_valid_reg && s1_cmd_reg.emit && out_free;
    assign pop      = !q_empty && s1_free;

    // dc += (c * (x - dc) + half) >> 16, same as the weighted sum form
    assign diff_f = $signed({1'b0, q_cmd.x, {dcrd_pkg::FRAC_BITS{1'b0}}})
                  - $signed({1'b0, dc_reg});
    assign coef_s = $signed({1'b0, filt_cfg.coeff});
    assign prod   = coef_s * diff_f;
    assign rnd    = prod + (PROD_W'(1) <<< (dcrd_pkg::FRAC_BITS - 1));
    assign step   = rnd >>> dcrd_pkg::FRAC_BITS;
    assign dc_next = dc_reg + step[dcrd_pkg::OFF_W-1:0];

    // centered value from the updated offset, truncated toward zero
    assign diff_o = $signed({1'b0, s1_cmd_reg.x, {dcrd_pkg::FRAC_BITS{1'b0}}})
                  - $signed({1'b0, dc_reg});
    assign ipart  = diff_o[dcrd_pkg::OFF_W:dcrd_pkg::FRAC_BITS];

    always_comb
    begin
        ipart_t = ipart;
        if (diff_o[dcrd_pkg::OFF_W] && (|diff_o[dcrd_pkg::FRAC_BITS-1:0]))
        begin
            ipart_t = ipart + 1'b1;
        end
    end

    assign ext = dcrd_pkg::PCM_W'(ipart_t);
    assign pcm = ext << filt_cfg.shift;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (pop)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_free)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dc_reg        <= dcrd_pkg::OFFSET_RESET;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                dc_reg <= dc_next;
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_cmd_reg <= q_cmd;
        end
        if (out_load)
        begin
            out_data_reg.pcm_sample   <= $signed(pcm);
            out_data_reg.last_of_clip <= s1_cmd_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ rtl/audio_dc_remove_decimate_capture_unit.sv @@
// channel   direction  beat contents
// in        in         op, adc_sample (sample or start command)
// out       out        pcm_sample, last_of_clip
// cfg       in         cfg_index, cfg_data (register write)
//
// one input beat per cycle when the result side keeps up; a kept sample passes
// through the queue, the filter register and the output register to out_valid
// the filter update is one 17x29 multiply and add per cycle while the back pops
// reset brings the registers to their defaults and the offset to mid scale
// a stalled result side fills the four-entry queue, then in_ready drops
module audio_dc_remove_decimate_capture_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  dcrd_pkg::in_item_t              in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output dcrd_pkg::out_item_t             out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dcrd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dcrd_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic                push;
    dcrd_pkg::cmd_t      push_cmd;
    logic                q_full;
    logic                q_empty;
    logic                pop;
    dcrd_pkg::cmd_t      pop_cmd;
    dcrd_pkg::filt_cfg_t filt_cfg;

    dcrd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .push      (push),
        .push_cmd  (push_cmd),
        .filt_cfg  (filt_cfg)
    );

    dcrd_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .pop_cmd  (pop_cmd)
    );

    dcrd_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_cmd     (pop_cmd),
        .pop       (pop),
        .filt_cfg  (filt_cfg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

@@ rtl/dcrd_checker.sv @@
`include "audio_dc_remove_decimate_capture_unit_assert.svh"

module dcrd_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input dcrd_pkg::out_item_t out_data,
    input logic                cfg_ready
);

    // a held result beat keeps its contents
    `DCRD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

    // the queue only fills on an accepted input beat
    `DCRD_ASSERT_NOW(a_ready_fall, $fell(in_ready), $past(in_valid && in_ready))

    // register writes are never back-pressured
    `DCRD_ASSERT_HOLDS(a_cfg_ready, cfg_ready)

endmodule

bind audio_dc_remove_decimate_capture_unit dcrd_checker u_dcrd_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_ready (cfg_ready)
);
